// File: rtl/page_framebuffer_with_flush_unit_assert.svh
// Assertion macros for the page frame buffer block.
// Define NO_ASSERTIONS to compile them away.
`ifndef PAGE_FRAMEBUFFER_WITH_FLUSH_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_WITH_FLUSH_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define PFB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pfb assertion failed");
// next-cycle implication, checked out of reset
`define PFB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pfb assertion failed");
`else
`define PFB_ASSERT_IMP(lbl, ante, cons)
`define PFB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/pfb_pkg.sv
package pfb_pkg;

    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 64;
    localparam int PAGE_ROWS        = 8;
    localparam int WORD_BITS        = 64;
    localparam int RAM_DEPTH_DEF    = 128;
    localparam int COLUMN_OFFSET    = 4;

    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [7:0] NIBBLE_LOW   = 8'h0F;
    localparam logic [7:0] NIBBLE_HIGH  = 8'hF0;
    localparam logic [7:0] BYTE_MASK    = 8'hFF;
    localparam logic [3:0] CMD_BYTES    = 4'd3;
    localparam logic [3:0] FULL_BYTES   = 4'd8;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CMD,
        S_DATA,
        S_TAIL
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic clearing;
    } t_seq_stat;

    // address bits for n entries, never below one
    function automatic int addr_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // cursor command for the given page at column zero plus panel offset
    function automatic logic [63:0] cursor_payload(input logic [7:0] page);
        logic [7:0] col;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        col = 8'(COLUMN_OFFSET) & BYTE_MASK;
        b0  = CMD_PAGE + page;
        b1  = CMD_COL_HIGH + ((col & NIBBLE_HIGH) >> 4);
        b2  = col & NIBBLE_LOW;
        return {40'd0, b2, b1, b0};
    endfunction

endpackage

// File: rtl/pfb_ram.sv
module pfb_ram #(
    parameter int WIDTH = pfb_pkg::WORD_BITS,
    parameter int DEPTH = pfb_pkg::RAM_DEPTH_DEF,
    localparam int AW = pfb_pkg::addr_bits(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pfb_pix.sv
module pfb_pix #(
    parameter int PANEL_WIDTH  = pfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = pfb_pkg::PANEL_HEIGHT_DEF,
    localparam int WB = pfb_pkg::addr_bits((PANEL_WIDTH + 7) / 8),
    localparam int PB = pfb_pkg::addr_bits((PANEL_HEIGHT + 7) / 8),
    localparam int AW = PB + WB
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [15:0]   i_x,
    input  logic [15:0]   i_y,
    input  logic          i_color,
    output logic [AW-1:0] o_rd_addr,
    input  logic [63:0]   i_rd_data,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [63:0]   o_wdata
);

    import pfb_pkg::*;

    logic          on_panel;
    logic          go;
    logic [AW-1:0] addr;
    logic [63:0]   base;
    logic [63:0]   mask;
    logic [7:0]    bmask;
    logic [63:0]   n_word;

    logic          r_pend;
    logic [AW-1:0] r_addr;
    logic [2:0]    r_lane;
    logic [2:0]    r_bit;
    logic          r_set;
    logic          r_hit;
    logic [63:0]   r_fwd;

    assign on_panel = !i_x[15] && ({1'b0, i_x[14:0]} < 16'(PANEL_WIDTH))
                   && !i_y[15] && ({1'b0, i_y[14:0]} < 16'(PANEL_HEIGHT));
    assign go       = i_take && on_panel;
    assign addr     = {PB'(i_y[14:3]), WB'(i_x[14:3])};

    assign o_rd_addr = addr;

    // take the word written last cycle when the read raced it
    assign base   = r_hit ? r_fwd : i_rd_data;
    assign bmask  = 8'h01 << r_bit;
    assign mask   = {56'd0, bmask} << {r_lane, 3'b000};
    assign n_word = r_set ? (base | mask) : (base & ~mask);

    assign o_we    = r_pend;
    assign o_waddr = r_addr;
    assign o_wdata = n_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_pend <= go;
            r_hit  <= go && r_pend && (addr == r_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_addr <= addr;
            r_lane <= i_x[2:0];
            r_bit  <= i_y[2:0];
            r_set  <= (i_color == 1'b0);
        end
        r_fwd <= n_word;
    end

endmodule

// File: rtl/pfb_seq.sv
module pfb_seq #(
    parameter int PANEL_WIDTH  = pfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = pfb_pkg::PANEL_HEIGHT_DEF,
    localparam int WB = pfb_pkg::addr_bits((PANEL_WIDTH + 7) / 8),
    localparam int PB = pfb_pkg::addr_bits((PANEL_HEIGHT + 7) / 8),
    localparam int AW = PB + WB
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_flush_go,
    input  logic [2:0]          i_page,
    input  logic [63:0]         i_rd_data,
    output logic [AW-1:0]       o_rd_addr,
    output logic                o_clr_we,
    output logic [AW-1:0]       o_clr_addr,
    output pfb_pkg::t_seq_stat  o_stat,
    output logic                o_strobe,
    output logic                o_is_command,
    output logic [3:0]          o_byte_count,
    output logic [63:0]         o_payload,
    output logic                o_last
);

    import pfb_pkg::*;

    localparam int NW         = (PANEL_WIDTH + 7) / 8;
    localparam int PAGE_COUNT = PANEL_HEIGHT / PAGE_ROWS;
    localparam int LAST_BYTES = PANEL_WIDTH - 8 * (NW - 1);

    t_seq_state    r_state;
    t_seq_state    n_state;
    logic [2:0]    r_page;
    logic          r_final;
    logic [WB-1:0] r_word;
    logic [AW-1:0] r_clr_addr;
    logic          last_word;

    assign last_word = (r_word == WB'(NW - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (&r_clr_addr) n_state = S_IDLE;
            S_IDLE:  if (i_flush_go) n_state = S_CMD;
            S_CMD:   n_state = S_DATA;
            S_DATA:  if (last_word) n_state = r_final ? S_TAIL : S_IDLE;
            S_TAIL:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_word     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_CMD) begin
                r_word <= '0;
            end else if (r_state == S_DATA) begin
                r_word <= r_word + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_flush_go) begin
            r_page  <= i_page;
            r_final <= (int'(i_page) == PAGE_COUNT - 1);
        end
    end

    always_comb begin
        o_stat.busy     = (r_state != S_IDLE);
        o_stat.clearing = (r_state == S_CLEAR);
        o_clr_we        = (r_state == S_CLEAR);
        o_clr_addr      = r_clr_addr;
        o_rd_addr       = '0;
        o_strobe        = 1'b0;
        o_is_command    = 1'b0;
        o_byte_count    = '0;
        o_payload       = '0;
        o_last          = 1'b0;
        case (r_state)
            S_CMD: begin
                o_rd_addr    = {PB'(r_page), WB'(0)};
                o_strobe     = 1'b1;
                o_is_command = 1'b1;
                o_byte_count = CMD_BYTES;
                o_payload    = cursor_payload(8'(r_page));
            end
            S_DATA: begin
                o_rd_addr    = {PB'(r_page), WB'(r_word + 1'b1)};
                o_strobe     = 1'b1;
                o_byte_count = last_word ? 4'(LAST_BYTES) : FULL_BYTES;
                o_payload    = i_rd_data;
                o_last       = last_word && !r_final;
            end
            S_TAIL: begin
                o_strobe     = 1'b1;
                o_is_command = 1'b1;
                o_byte_count = CMD_BYTES;
                o_payload    = cursor_payload(8'd0);
                o_last       = 1'b1;
            end
            default: begin
                o_strobe = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/page_framebuffer_with_flush_unit.sv
// Pixel writes: one beat per cycle while idle, no result; read-modify-write of a 64-bit word.
// Flush: first beat in the cycle after accept, then one beat per cycle, 18 beats for the last page
//   and 17 for others at 128 columns; busy until the final beat, set by the one memory read port.
// Reset (synchronous, active low) starts a clearing pass over all 2**(page bits + word bits)
//   words, 128 by default, with busy high; results cannot be stalled by the receiver.
`include "page_framebuffer_with_flush_unit_assert.svh"

module page_framebuffer_with_flush_unit #(
    parameter int PANEL_WIDTH  = pfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = pfb_pkg::PANEL_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    input  logic        i_color,
    input  logic [2:0]  i_page,
    output logic        o_strobe,
    output logic        o_is_command,
    output logic [3:0]  o_byte_count,
    output logic [63:0] o_payload,
    output logic        o_last
);

    import pfb_pkg::*;

    // The store is 64 bits wide: one word holds eight column bytes of one page,
    // so a flush streams one data beat per memory read.
    localparam int NW         = (PANEL_WIDTH + 7) / 8;
    localparam int WB         = addr_bits(NW);
    localparam int PB         = addr_bits((PANEL_HEIGHT + 7) / 8);
    localparam int AW         = PB + WB;
    localparam int DEPTH      = 2 ** AW;
    localparam int PAGE_COUNT = PANEL_HEIGHT / PAGE_ROWS;

    t_seq_stat     stat;
    logic          take;
    logic          pix_take;
    logic          flush_go;

    logic [AW-1:0] pix_rd_addr;
    logic          pix_we;
    logic [AW-1:0] pix_waddr;
    logic [63:0]   pix_wdata;

    logic [AW-1:0] seq_rd_addr;
    logic          clr_we;
    logic [AW-1:0] clr_addr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    assign busy     = stat.busy;
    assign take     = start && !stat.busy;
    assign pix_take = take && (i_kind == KIND_PIXEL);
    // drop a flush of a page beyond the panel: no beats at all
    assign flush_go = take && (i_kind == KIND_FLUSH) && (int'(i_page) < PAGE_COUNT);

    pfb_pix #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_pix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (pix_take),
        .i_x       (i_x),
        .i_y       (i_y),
        .i_color   (i_color),
        .o_rd_addr (pix_rd_addr),
        .i_rd_data (ram_rdata),
        .o_we      (pix_we),
        .o_waddr   (pix_waddr),
        .o_wdata   (pix_wdata)
    );

    pfb_seq #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_flush_go   (flush_go),
        .i_page       (i_page),
        .i_rd_data    (ram_rdata),
        .o_rd_addr    (seq_rd_addr),
        .o_clr_we     (clr_we),
        .o_clr_addr   (clr_addr),
        .o_stat       (stat),
        .o_strobe     (o_strobe),
        .o_is_command (o_is_command),
        .o_byte_count (o_byte_count),
        .o_payload    (o_payload),
        .o_last       (o_last)
    );

    // Hand the write port to the clearing pass while it runs, else to the pixel stage.
    // A pixel still in flight when a flush is taken lands before the first flush read.
    assign ram_we    = clr_we || pix_we;
    assign ram_waddr = stat.clearing ? clr_addr : pix_waddr;
    assign ram_wdata = stat.clearing ? 64'd0 : pix_wdata;
    // idle: the read port follows the pixel coordinates; busy: the sequencer, which walks the page in a flush
    assign ram_raddr = stat.busy ? seq_rd_addr : pix_rd_addr;

    pfb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    `PFB_ASSERT_IMP(a_no_pixel_in_clear, stat.clearing, !pix_we)
    `PFB_ASSERT_NXT(a_flush_starts_cmd, flush_go, o_strobe && o_is_command && !o_last)
    `PFB_ASSERT_NXT(a_idle_after_last, o_strobe && o_last, !busy)
    `PFB_ASSERT_IMP(a_data_from_walk, o_strobe && !o_is_command, busy && !stat.clearing)

endmodule
